// ===== design/rete_pkg.sv =====
package rete_pkg;

  // Speed word: signed Q32.16.
  localparam int SPD_W  = 48;
  localparam int FRAC_W = 16;
  // Headroom for speed updates before saturation.
  localparam int SUM_W  = SPD_W + 3;

  // Bit-serial divider, one quotient bit per cycle.
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Shift-add multiplier: unsigned weight times signed difference.
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = SPD_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_A_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [16:0] ALPHA_RST     = 17'd6554;
  localparam logic [7:0]  WARMUP_RST    = 8'd10;
  localparam logic [31:0] START_T_RST   = 32'd0;
  localparam logic [31:0] START_L_RST   = 32'd0;
  localparam logic [15:0] DEAD_BAND_RST = 16'd7;

  // A weight of exactly one in Q1.16.
  localparam logic [MUL_A_W-1:0] ALPHA_ONE = 17'd65536;

endpackage

// ===== design/rate_ema_time_to_goal.sv =====
// A reading that is accepted is first divided for its slope; a warmup step then divides that
// slope by the warmup count, while a smoothing step uses the shift-add multiplier. A time
// division follows unless the estimate is unavailable; a reading that is not accepted goes
// straight to that step. The bit-serial divider gives up to three quotients per request.
// One request is in work at a time, and the next can be taken in the cycle after the result
// is loaded. Synchronous reset restores configuration defaults and clears the speed state.
module rate_ema_time_to_goal import rete_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          stamp,
  input  logic [31:0]          level,
  input  logic [31:0]          goal,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [SPD_W-1:0] rate,
  output logic [31:0]          ticks_left,
  output logic                 estimate_valid,
  output logic                 accepted,
  output logic                 warming,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [ST_W-1:0] ST_SLOPE_GO   = 4'd1;
  localparam logic [ST_W-1:0] ST_SLOPE_WAIT = 4'd2;
  localparam logic [ST_W-1:0] ST_WARM_GO    = 4'd3;
  localparam logic [ST_W-1:0] ST_WARM_WAIT  = 4'd4;
  localparam logic [ST_W-1:0] ST_EMA_GO     = 4'd5;
  localparam logic [ST_W-1:0] ST_EMA_WAIT   = 4'd6;
  localparam logic [ST_W-1:0] ST_TIME_PREP  = 4'd7;
  localparam logic [ST_W-1:0] ST_TIME_GO    = 4'd8;
  localparam logic [ST_W-1:0] ST_TIME_WAIT  = 4'd9;
  localparam logic [ST_W-1:0] ST_OUT        = 4'd10;

  localparam logic [SPD_W-1:0]  SPD_HALF = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic [SPD_W-1:0]  SPD_MAXU = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic [PROD_W-1:0] EMA_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Clamp a widened speed sum into the signed speed range.
  function automatic logic [SPD_W-1:0] sat_spd(input logic [SUM_W-1:0] v);
    logic [SPD_W-1:0] r;
    if ((&v[SUM_W-1:SPD_W-1]) || !(|v[SUM_W-1:SPD_W-1])) begin
      r = v[SPD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = SPD_HALF;
    end else begin
      r = SPD_MAXU;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [16:0] alpha;
  logic [7:0]  warmup_count;
  logic [31:0] start_time;
  logic [31:0] start_level;
  logic [15:0] dead_band;

  // Block state.
  logic [ST_W-1:0]  state;
  logic [31:0]      last_stamp;
  logic [31:0]      last_level;
  logic [SPD_W-1:0] speed;
  logic [7:0]       slopes_seen;

  // Per-request working registers.
  logic [31:0]      stamp_r;
  logic [31:0]      level_r;
  logic [31:0]      goal_r;
  logic             acc_r;
  logic             neg_r;
  logic             valid_r;
  logic [31:0]      ticks_r;
  logic [SPD_W-1:0] slope_r;
  logic [DIV_W-1:0] op_a;
  logic [DIV_W-1:0] op_b;

  // Shared unit handshakes.
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic             mul_start;
  logic             mul_busy;
  logic             mul_done;
  logic signed [PROD_W-1:0] mul_prod;

  // Combinational helpers.
  logic               in_take;
  logic               out_take;
  logic               out_load;
  logic               acc_now;
  logic               rise_neg;
  logic [31:0]        run_now;
  logic [31:0]        rmag_now;
  logic [SPD_W-1:0]   slope_mag;
  logic [SPD_W-1:0]   slope_val;
  logic               warm_now;
  logic [MUL_A_W-1:0] alpha_eff;
  logic signed [MUL_B_W-1:0] ema_diff;
  logic [PROD_W-1:0]  ema_round;
  logic [SUM_W-1:0]   ema_sum;
  logic [SUM_W-1:0]   warm_term;
  logic [SUM_W-1:0]   warm_sum;
  logic [SPD_W-1:0]   speed_mag;
  logic [31:0]        goal_gap;
  logic               est_now;

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  // Slope setup for a new reading.
  always_comb begin
    acc_now  = (level != last_level) && (stamp > last_stamp);
    rise_neg = level < last_level;
    run_now  = stamp - last_stamp;
    rmag_now = rise_neg ? (last_level - level) : (level - last_level);
  end

  // Saturated slope from the divider quotient.
  always_comb begin
    if (neg_r) begin
      slope_mag = div_quo[DIV_W-1] ? SPD_HALF : div_quo;
    end else begin
      slope_mag = div_quo[DIV_W-1] ? SPD_MAXU : div_quo;
    end
    slope_val = neg_r ? (SPD_W'(0) - slope_mag) : slope_mag;
  end

  // Speed update terms for warmup and smoothing.
  always_comb begin
    warm_now  = slopes_seen < warmup_count;
    alpha_eff = alpha[16] ? ALPHA_ONE : alpha;
    ema_diff  = $signed({slope_r[SPD_W-1], slope_r}) - $signed({speed[SPD_W-1], speed});
    ema_round = mul_prod + EMA_HALF;
    ema_sum   = {{(SUM_W-SPD_W){speed[SPD_W-1]}}, speed}
              + {{(SUM_W-(PROD_W-FRAC_W)){ema_round[PROD_W-1]}},
                 ema_round[PROD_W-1:FRAC_W]};
    warm_term = neg_r ? (SUM_W'(0) - {{(SUM_W-DIV_W){1'b0}}, div_quo})
                      : {{(SUM_W-DIV_W){1'b0}}, div_quo};
    warm_sum  = {{(SUM_W-SPD_W){speed[SPD_W-1]}}, speed} + warm_term;
  end

  // Time-to-goal setup.
  always_comb begin
    speed_mag = speed[SPD_W-1] ? (SPD_W'(0) - speed) : speed;
    goal_gap  = (goal_r >= last_level) ? (goal_r - last_level) : (last_level - goal_r);
    est_now   = (speed_mag != '0) && (speed_mag >= {{(SPD_W-16){1'b0}}, dead_band});
  end

  assign div_start = (state == ST_SLOPE_GO) || (state == ST_WARM_GO) ||
                     (state == ST_TIME_GO);
  assign mul_start = (state == ST_EMA_GO);

  rete_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  rete_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (ema_diff),
    .mplier  (alpha_eff),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Sequencer, block state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      alpha        <= ALPHA_RST;
      warmup_count <= WARMUP_RST;
      start_time   <= START_T_RST;
      start_level  <= START_L_RST;
      dead_band    <= DEAD_BAND_RST;
      last_stamp   <= START_T_RST;
      last_level   <= START_L_RST;
      speed        <= '0;
      slopes_seen  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= acc_now ? ST_SLOPE_GO : ST_TIME_PREP;
          end
        end
        ST_SLOPE_GO: begin
          state <= ST_SLOPE_WAIT;
        end
        ST_SLOPE_WAIT: begin
          if (div_done) begin
            state <= warm_now ? ST_WARM_GO : ST_EMA_GO;
          end
        end
        ST_WARM_GO: begin
          state <= ST_WARM_WAIT;
        end
        ST_WARM_WAIT: begin
          if (div_done) begin
            speed       <= sat_spd(warm_sum);
            slopes_seen <= slopes_seen + 1'b1;
            last_stamp  <= stamp_r;
            last_level  <= level_r;
            state       <= ST_TIME_PREP;
          end
        end
        ST_EMA_GO: begin
          state <= ST_EMA_WAIT;
        end
        ST_EMA_WAIT: begin
          if (mul_done) begin
            speed      <= sat_spd(ema_sum);
            last_stamp <= stamp_r;
            last_level <= level_r;
            state      <= ST_TIME_PREP;
          end
        end
        ST_TIME_PREP: begin
          state <= est_now ? ST_TIME_GO : ST_OUT;
        end
        ST_TIME_GO: begin
          state <= ST_TIME_WAIT;
        end
        ST_TIME_WAIT: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Writes are taken only while the block is idle.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ALPHA:       alpha        <= cfg_data[16:0];
          REG_WARMUP:      warmup_count <= cfg_data[7:0];
          REG_START_TIME: begin
            start_time <= cfg_data;
            last_stamp <= cfg_data;
          end
          REG_START_LEVEL: begin
            start_level <= cfg_data;
            last_level  <= cfg_data;
          end
          REG_DEAD_BAND:   dead_band    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      stamp_r <= stamp;
      level_r <= level;
      goal_r  <= goal;
      acc_r   <= acc_now;
      neg_r   <= rise_neg;
      op_a    <= {rmag_now, {FRAC_W{1'b0}}};
      op_b    <= {{(DIV_W-32){1'b0}}, run_now};
    end
    if ((state == ST_SLOPE_WAIT) && div_done) begin
      slope_r <= slope_val;
      op_a    <= slope_mag;
      op_b    <= {{(DIV_W-8){1'b0}}, warmup_count};
    end
    if (state == ST_TIME_PREP) begin
      valid_r <= est_now;
      ticks_r <= '1;
      op_a    <= {goal_gap, {FRAC_W{1'b0}}};
      op_b    <= speed_mag;
    end
    if ((state == ST_TIME_WAIT) && div_done) begin
      ticks_r <= (|div_quo[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
    end
    if (out_load) begin
      rate           <= speed;
      ticks_left     <= ticks_r;
      estimate_valid <= valid_r;
      accepted       <= acc_r;
      warming        <= warm_now;
    end
  end

`ifndef SYNTHESIS
  // The shared units are never restarted while still iterating.
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) mul_start |-> !mul_busy)
    else $error("multiplier started while busy");
  // A result is only loaded from the final sequencer step.
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result appeared outside the output step");
  // An unavailable estimate always reports the saturated time.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !estimate_valid) |-> (ticks_left == 32'hFFFF_FFFF))
    else $error("unavailable estimate with finite time");
`endif

endmodule

// ===== design/rete_div.sv =====
module rete_div import rete_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       trial_sub;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem, quo[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs};
  end

  // Control: run for one step per quotient bit, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial_sub[DIV_W]) begin
        rem <= trial_sub[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== design/rete_mul.sv =====
module rete_mul import rete_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_B_W-1:0] mcand,
  input  logic        [MUL_A_W-1:0] mplier,
  output logic                      busy,
  output logic                      done,
  output logic signed [PROD_W-1:0]  product
);

  logic [MUL_CNT_W-1:0]       cnt;
  logic signed [MUL_B_W-1:0]  mcand_r;
  logic [MUL_A_W-1:0]         mpl;
  logic signed [PROD_W-1:0]   acc;
  logic signed [PROD_W-1:0]   addend;

  // Multiplier bits are taken most significant first.
  always_comb begin
    if (mpl[MUL_A_W-1]) begin
      addend = {{(PROD_W - MUL_B_W){mcand_r[MUL_B_W-1]}}, mcand_r};
    end else begin
      addend = '0;
    end
  end

  // Control: one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: double the partial sum and add the selected multiplicand.
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      mcand_r <= mcand;
      mpl     <= mplier;
    end else if (busy) begin
      acc <= {acc[PROD_W-2:0], 1'b0} + addend;
      mpl <= {mpl[MUL_A_W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import rete_pkg::*;

  // Cycles the receiver holds off in one long stretch, and the overall time limit.
  localparam int HOLD_CYCLES = 600;
  localparam int END_CYCLES  = 200;
  localparam int RUN_LIMIT   = 8_000_000;

  // An index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  // Bounds of the signed Q32.16 speed word, held at a width that cannot overflow.
  localparam logic signed [79:0] RATE_MAX = 80'sh7FFF_FFFF_FFFF;
  localparam logic signed [79:0] RATE_MIN = -RATE_MAX - 80'sd1;
  localparam logic [63:0] SLOPE_NEG_LIMIT = 64'h8000_0000_0000;

  typedef struct packed {
    logic [SPD_W-1:0] rate;
    logic [31:0]      ticks_left;
    logic             estimate_valid;
    logic             accepted;
    logic             warming;
  } est_result_t;

  typedef enum int {FLOW, LIGHT, HEAVY, BLOCKED} stall_mode_t;

  // Tracks the speed estimator state and the results still owed by the block.
  class ema_scoreboard;
    logic [16:0] alpha;
    logic [7:0]  warmup;
    logic [15:0] dead_band;
    logic [31:0] prev_stamp;
    logic [31:0] prev_level;
    logic signed [63:0] speed;
    logic [7:0]  slope_count;
    est_result_t owed[$];
    int errors, results, updates, warm_updates, valid_estimates;

    function new();
      alpha       = ALPHA_RST;
      warmup      = WARMUP_RST;
      dead_band   = DEAD_BAND_RST;
      prev_stamp  = START_T_RST;
      prev_level  = START_L_RST;
      speed       = 0;
      slope_count = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function logic signed [63:0] clamp48(logic signed [79:0] v);
      if (v > RATE_MAX) return RATE_MAX[63:0];
      if (v < RATE_MIN) return RATE_MIN[63:0];
      return v[63:0];
    endfunction

    function logic [63:0] magnitude(logic signed [63:0] v);
      return (v < 0) ? -v : v;
    endfunction

    // Start writes also reload the reference point of the slope.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_ALPHA:       alpha = data[16:0];
        REG_WARMUP:      warmup = data[7:0];
        REG_START_TIME:  prev_stamp = data;
        REG_START_LEVEL: prev_level = data;
        REG_DEAD_BAND:   dead_band = data[15:0];
        default: ;
      endcase
    endfunction

    // Advances the estimator by one accepted request and queues its result.
    function void note_request(logic [31:0] st, logic [31:0] lv, logic [31:0] gl);
      logic took, neg;
      logic [31:0] run, rise, goal_gap;
      logic [63:0] q, tm, sm, ticks;
      logic signed [63:0] slope, term;
      logic signed [79:0] wa, wb, mix;
      logic [16:0] a;
      est_result_t r;
      took = (lv != prev_level) && (st > prev_stamp);
      if (took) begin
        run  = st - prev_stamp;
        neg  = lv < prev_level;
        rise = neg ? prev_level - lv : lv - prev_level;
        q = ({32'd0, rise} << 16) / run;
        if (neg) begin
          slope = (q >= SLOPE_NEG_LIMIT) ? RATE_MIN[63:0] : -$signed(q);
        end else begin
          slope = (q > RATE_MAX[63:0]) ? RATE_MAX[63:0] : $signed(q);
        end
        if (slope_count < warmup) begin
          // Warmup: add the slope's share, truncated toward zero.
          tm = magnitude(slope) / warmup;
          term = (slope < 0) ? -$signed(tm) : $signed(tm);
          speed = clamp48(speed + term);
          slope_count = slope_count + 8'd1;
          warm_updates++;
        end else begin
          // Smoothing: weighted mix, rounded to nearest with ties upward.
          a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
          wa = {63'd0, a};
          wb = 80'sd65536 - wa;
          mix = wa * slope + wb * speed + 80'sd32768;
          speed = clamp48(mix >>> 16);
        end
        prev_stamp = st;
        prev_level = lv;
        updates++;
      end
      sm = magnitude(speed);
      r.estimate_valid = (sm != 0) && (sm >= dead_band);
      r.ticks_left = 32'hFFFF_FFFF;
      if (r.estimate_valid) begin
        goal_gap = (gl >= prev_level) ? gl - prev_level : prev_level - gl;
        ticks = ({32'd0, goal_gap} << 16) / sm;
        r.ticks_left = (ticks > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ticks[31:0];
        valid_estimates++;
      end
      r.rate     = speed[SPD_W-1:0];
      r.accepted = took;
      r.warming  = slope_count < warmup;
      owed.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(est_result_t got);
      est_result_t want;
      results++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting: actual %h", $time, got);
        return;
      end
      want = owed.pop_front();
      compare("rate", want.rate, got.rate);
      compare("ticks_left", want.ticks_left, got.ticks_left);
      compare("estimate_valid", want.estimate_valid, got.estimate_valid);
      compare("accepted", want.accepted, got.accepted);
      compare("warming", want.warming, got.warming);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          stamp = '0;
  logic [31:0]          level = '0;
  logic [31:0]          goal = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SPD_W-1:0]     rate;
  logic [31:0]          ticks_left;
  logic                 estimate_valid;
  logic                 accepted;
  logic                 warming;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic long_hold = 1'b0;
  int   settings = 0;
  ema_scoreboard sb = new();

  rate_ema_time_to_goal DUT (.*);

  always #1 clk = ~clk;

  // Results are checked at the rising edge they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({rate, ticks_left, estimate_valid, accepted, warming});
    end
  end

  // Receiver back-pressure: random modes of random length, plus one long hold-off.
  initial begin
    stall_mode_t mode;
    int span;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(1, 64);
      if (long_hold) begin
        long_hold = 1'b0;
        mode = BLOCKED;
        span = HOLD_CYCLES;
      end
      repeat (span) begin
        @(negedge clk);
        case (mode)
          FLOW:    out_stall = 1'b0;
          LIGHT:   out_stall = ($urandom_range(0, 3) == 0);
          HEAVY:   out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = 1'b1;
        endcase
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] w, logic [31:0] t0,
                          logic [31:0] l0, logic [31:0] db);
    cfg_write(REG_ALPHA, a);
    cfg_write(REG_WARMUP, w);
    cfg_write(REG_START_TIME, t0);
    cfg_write(REG_START_LEVEL, l0);
    cfg_write(REG_DEAD_BAND, db);
    settings++;
  endtask

  // One request: valid stays high from the previous one unless a gap lowered it.
  task automatic offer(logic [31:0] st, logic [31:0] lv, logic [31:0] gl);
    @(negedge clk);
    in_valid = 1'b1;
    stamp    = st;
    level    = lv;
    goal     = gl;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(st, lv, gl);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain();
    pause(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly forward-moving readings with a changed level; the rest are
  // unchanged readings, backward stamps and unrelated noise.
  task automatic next_reading(output logic [31:0] st, output logic [31:0] lv,
                              output logic [31:0] gl);
    int pick, sel;
    logic [31:0] run, delta;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (sel == 0) run = 1;
    else if (sel < 7) run = $urandom_range(1, 1000);
    else if (sel < 9) run = $urandom_range(1, 65535);
    else run = $urandom_range(1, 1 << 24);
    sel = $urandom_range(0, 2);
    if (sel == 0) delta = $urandom_range(1, 16);
    else if (sel == 1) delta = $urandom_range(1, 65535);
    else delta = $urandom;
    if (delta == 0) delta = 1;
    st = sb.prev_stamp + run;
    lv = $urandom_range(0, 1) ? sb.prev_level + delta : sb.prev_level - delta;
    if (pick >= 75 && pick < 85) begin
      lv = sb.prev_level;
    end else if (pick >= 85 && pick < 93) begin
      st = sb.prev_stamp - $urandom_range(0, 1000);
    end else if (pick >= 93) begin
      st = $urandom;
      lv = $urandom;
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) gl = $urandom;
    else if (sel < 8) gl = sb.prev_level + $urandom_range(0, 4096) - 2048;
    else if (sel == 8) gl = lv;
    else gl = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
  endtask

  // Random requests sent in bursts; optionally drains once partway through.
  task automatic run_random(int n, int drain_at);
    int burst, sel;
    logic [31:0] st, lv, gl;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (i == drain_at) drain();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        sel = $urandom_range(0, 7);
        if (sel >= 4 && sel < 7) pause($urandom_range(1, 8));
        else if (sel == 7) pause($urandom_range(50, 250));
      end
      next_reading(st, lv, gl);
      offer(st, lv, gl);
      burst--;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: rejected readings, saturated slopes both ways, a vanishing slope.
    offer(32'd0, 32'd5, 32'd100);
    offer(32'd10, 32'd0, 32'd100);
    offer(32'd1, 32'hFFFF_FFFF, 32'd0);
    offer(32'd2, 32'd0, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'd1, 32'd0);
    offer(32'hFFFF_FFFF, 32'd2, 32'd5);
    run_random(60, -1);
    drain();

    // Weight of one, no warmup, no dead band: zero speed stays unavailable.
    set_regs(32'd65536, 32'd0, 32'd1000, 32'd5000, 32'd0);
    offer(32'd1049576, 32'd5001, 32'd5001);
    offer(32'd1049577, 32'd5004, 32'd5004);
    offer(32'd1049584, 32'd908, 32'd0);
    run_random(150, -1);
    drain();

    // Weight above one, widest dead band; the receiver holds off for a while.
    set_regs(32'd131071, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd65535);
    long_hold = 1'b1;
    run_random(150, -1);
    drain();

    set_regs(32'd0, 32'd255, 32'd12345, 32'h8000_0000, 32'd1);
    cfg_write(REG_SPARE, $urandom);
    run_random(150, -1);
    drain();

    set_regs(32'd6554, 32'd10, $urandom_range(0, 32'h7FFF_FFFF), $urandom, 32'd7);
    run_random(160, 80);
    drain();

    set_regs(32'd1, 32'd3, 32'd0, 32'd0, 32'd100);
    run_random(150, -1);
    drain();

    // Stamps start near the top, so few readings can move forward.
    set_regs(32'd32768, 32'd20, 32'hFFFF_FFF0, $urandom, $urandom_range(0, 65535));
    run_random(20, -1);
    drain();

    // Unused upper bits of the write data must be ignored.
    set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(150, -1);
    drain();

    set_regs(32'd65535, 32'd2, $urandom_range(0, 32'h7FFF_FFFF), $urandom,
             $urandom_range(0, 65535));
    run_random(150, -1);
    drain();

    set_regs($urandom_range(0, 131071), $urandom_range(0, 255),
             $urandom_range(0, 32'h7FFF_FFFF), $urandom, $urandom_range(0, 65535));
    run_random(150, -1);
    drain();

    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d readings under %0d register settings plus reset defaults.",
             sb.results, settings);
    $display("Speed updated %0d times (%0d in warmup); %0d estimates were valid.",
             sb.updates, sb.warm_updates, sb.valid_estimates);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    #RUN_LIMIT;
    $display("Timed out with %0d results still owed.", sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

endmodule
